### rtl/core/afd_pkg.sv
`default_nettype none

package afd_pkg;

	// Header and length limits of the frame format.
	localparam logic [7:0] HDR_FIRST  = 8'hFF;
	localparam logic [7:0] HDR_SECOND = 8'h55;
	localparam logic [7:0] FIXED_PART = 8'd3;
	localparam logic [7:0] MAX_LENGTH = 8'd251;

	// Kinds of result words.
	localparam logic KIND_PARAM = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef enum logic [7:0] {
		PH_HUNT  = 8'b0000_0001,
		PH_HDR2  = 8'b0000_0010,
		PH_LEN   = 8'b0000_0100,
		PH_MODE  = 8'b0000_1000,
		PH_CMDH  = 8'b0001_0000,
		PH_CMDL  = 8'b0010_0000,
		PH_PARAM = 8'b0100_0000,
		PH_CHECK = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] command;
		logic [7:0]  mode;
		logic [7:0]  data;
		logic [7:0]  index;
		logic [7:0]  count;
		logic        last;
	} item_t;

endpackage

`default_nettype wire

### rtl/core/afd_parser.sv
`default_nettype none

module afd_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     rx_byte,
	input  wire logic           q_full,
	output logic                push,
	output afd_pkg::item_t      push_item
);

	afd_pkg::phase_t phase_q;
	afd_pkg::phase_t phase_d;
	logic [7:0]      param_total_q;
	logic [7:0]      param_seen_q;
	logic [15:0]     cmd_q;
	logic [7:0]      mode_q;
	logic            accept;
	logic [7:0]      seen_inc;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign seen_inc = param_seen_q + 8'd1;

	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			afd_pkg::PH_HUNT: begin
				if (rx_byte == afd_pkg::HDR_FIRST) phase_d = afd_pkg::PH_HDR2;
			end
			afd_pkg::PH_HDR2: begin
				if (rx_byte == afd_pkg::HDR_SECOND) phase_d = afd_pkg::PH_LEN;
				else if (rx_byte == afd_pkg::HDR_FIRST) phase_d = afd_pkg::PH_HDR2;
				else phase_d = afd_pkg::PH_HUNT;
			end
			afd_pkg::PH_LEN: begin
				if (rx_byte < afd_pkg::FIXED_PART || rx_byte > afd_pkg::MAX_LENGTH) begin
					phase_d = afd_pkg::PH_HUNT;
				end else begin
					phase_d = afd_pkg::PH_MODE;
				end
			end
			afd_pkg::PH_MODE: phase_d = afd_pkg::PH_CMDH;
			afd_pkg::PH_CMDH: phase_d = afd_pkg::PH_CMDL;
			afd_pkg::PH_CMDL: begin
				phase_d = (param_total_q == 8'd0) ? afd_pkg::PH_CHECK : afd_pkg::PH_PARAM;
			end
			afd_pkg::PH_PARAM: begin
				if (seen_inc >= param_total_q) phase_d = afd_pkg::PH_CHECK;
			end
			afd_pkg::PH_CHECK: phase_d = afd_pkg::PH_HUNT;
			default: phase_d = afd_pkg::PH_HUNT;
		endcase
	end

	// Parameter bytes and the checksum byte each give one word.
	always_comb begin
		push              = accept && (phase_q == afd_pkg::PH_PARAM ||
		                               phase_q == afd_pkg::PH_CHECK);
		push_item.command = cmd_q;
		push_item.mode    = mode_q;
		push_item.count   = param_total_q;
		if (phase_q == afd_pkg::PH_PARAM) begin
			push_item.kind  = afd_pkg::KIND_PARAM;
			push_item.data  = rx_byte;
			push_item.index = param_seen_q;
			push_item.last  = 1'b0;
		end else begin
			push_item.kind  = afd_pkg::KIND_END;
			push_item.data  = 8'd0;
			push_item.index = 8'd0;
			push_item.last  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= afd_pkg::PH_HUNT;
			param_total_q <= 8'd0;
			param_seen_q  <= 8'd0;
			cmd_q         <= 16'd0;
			mode_q        <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			unique case (phase_q)
				afd_pkg::PH_LEN: begin
					if (phase_d == afd_pkg::PH_MODE) begin
						param_total_q <= rx_byte - afd_pkg::FIXED_PART;
						param_seen_q  <= 8'd0;
					end
				end
				afd_pkg::PH_MODE:  mode_q        <= rx_byte;
				afd_pkg::PH_CMDH:  cmd_q         <= {rx_byte, 8'd0};
				afd_pkg::PH_CMDL:  cmd_q[7:0]    <= rx_byte;
				afd_pkg::PH_PARAM: param_seen_q  <= seen_inc;
				default: ;
			endcase
		end
	end

	// The parameter phase is only entered with a nonzero parameter count.
	a_param_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == afd_pkg::PH_PARAM |-> param_total_q != 8'd0)
		else $error("parameter phase with zero parameter count");

endmodule

`default_nettype wire

### rtl/core/afd_fifo.sv
`default_nettype none

module afd_fifo #(
	parameter int DEPTH = 2
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire afd_pkg::item_t push_item,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output afd_pkg::item_t      pop_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	afd_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

	a_count_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> count_q == $past(count_q) - CW'(1))
		else $error("queue count did not drop on read");

endmodule

`default_nettype wire

### rtl/core/afd_emit.sv
`default_nettype none

module afd_emit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_not_empty,
	input  wire afd_pkg::item_t q_item,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output afd_pkg::item_t      out_item
);

	logic           valid_q;
	afd_pkg::item_t item_q;

	// The output register reloads whenever it is empty or being drained.
	assign pop       = q_not_empty && (!valid_q || out_ready);
	assign out_valid = valid_q;
	assign out_item  = item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || out_ready) begin
			valid_q <= q_not_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= q_item;
	end

endmodule

`default_nettype wire

### rtl/core/accessory_frame_deframer.sv
`default_nettype none

// Channel | Direction | Handshake            | Payload
// input   | in        | in_valid / in_ready  | rx_byte
// result  | out       | out_valid/ out_ready | item_kind, command, frame_mode, param_byte,
//         |           |                      | param_index, param_count, frame_last
//
// One byte word is accepted per cycle while the queue is not full; the parser state machine
// decides each byte in the cycle it arrives, so the rate is set by that single state update.
// A result word is written into the queue and then into the output register, and leaves
// when out_ready is high; a full word stream runs at one word per cycle while it stays high.
// When the output is stalled, the queue between parser and output register absorbs
// up to QUEUE_DEPTH words before in_ready drops.
// Reset is asynchronous and active low; the parser returns to hunting for the header
// and the queue and output register come up empty.

module accessory_frame_deframer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             item_kind,
	output logic [15:0]      command,
	output logic [7:0]       frame_mode,
	output logic [7:0]       param_byte,
	output logic [7:0]       param_index,
	output logic [7:0]       param_count,
	output logic             frame_last
);

	afd_pkg::item_t push_item;
	afd_pkg::item_t q_item;
	afd_pkg::item_t out_item;
	logic           push;
	logic           pop;
	logic           q_full;
	logic           q_not_empty;

	// The front end hunts for the header, tracks the frame fields and turns every
	// parameter byte and checksum byte into one result word.
	afd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// The queue decouples the parser from a stalled consumer.
	afd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.pop_item  (q_item)
	);

	// The back end holds the word that is on offer at the output ports.
	afd_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_item      (q_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

	assign item_kind   = out_item.kind;
	assign command     = out_item.command;
	assign frame_mode  = out_item.mode;
	assign param_byte  = out_item.data;
	assign param_index = out_item.index;
	assign param_count = out_item.count;
	assign frame_last  = out_item.last;

endmodule

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// Roughly how many input bytes the run sends before it stops.
	localparam int IN_BYTES    = 1700;
	// Cycles after the last result before the run is closed.
	localparam int SETTLE      = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_LIMIT  = 10;

	// One row of the directed table. When typed is set, the row carries the
	// result word by hand; otherwise the predictor decides what is expected.
	typedef struct {
		logic [7:0]     b;
		bit             typed;
		afd_pkg::item_t want;
	} row_t;

	localparam afd_pkg::item_t NO_WORD = '0;
	// Shortest legal frame: length 3, mode and command bytes at 0xFF.
	localparam afd_pkg::item_t END_FULL = '{afd_pkg::KIND_END, 16'hFFFF, 8'hFF, 8'h00,
		8'd0, 8'd0, 1'b1};
	// Frame with a single parameter byte 0xFF, mode and command at zero.
	localparam afd_pkg::item_t PAR_ONE  = '{afd_pkg::KIND_PARAM, 16'h0000, 8'h00, 8'hFF,
		8'd0, 8'd1, 1'b0};
	localparam afd_pkg::item_t END_ONE  = '{afd_pkg::KIND_END, 16'h0000, 8'h00, 8'h00,
		8'd0, 8'd1, 1'b1};

	localparam int DIR_ROWS = 25;
	row_t dir_tab [DIR_ROWS] = '{
		'{8'h00, 1'b0, NO_WORD},	// Dropped while hunting.
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},	// A second 0xFF restarts the header.
		'{8'h55, 1'b0, NO_WORD},
		'{8'h02, 1'b0, NO_WORD},	// Length too short, frame dropped.
		'{8'hFF, 1'b0, NO_WORD},
		'{8'h55, 1'b0, NO_WORD},
		'{8'hFC, 1'b0, NO_WORD},	// Length too long, frame dropped.
		'{8'hFF, 1'b0, NO_WORD},
		'{8'h12, 1'b0, NO_WORD},	// Broken header.
		'{8'hFF, 1'b0, NO_WORD},
		'{8'h55, 1'b0, NO_WORD},
		'{8'h03, 1'b0, NO_WORD},	// No parameters at all.
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'hFF, 1'b0, NO_WORD},
		'{8'h00, 1'b1, END_FULL},	// Checksum closes the frame.
		'{8'hFF, 1'b0, NO_WORD},
		'{8'h55, 1'b0, NO_WORD},
		'{8'h04, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'h00, 1'b0, NO_WORD},
		'{8'hFF, 1'b1, PAR_ONE},
		'{8'hAA, 1'b1, END_ONE}
	};

	// Clock, reset and the ports of the block. Every input starts at a known value.
	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic [7:0]  rx_byte   = 8'h00;
	logic        out_ready = 1'b0;
	logic        in_ready;
	logic        out_valid;
	logic        item_kind;
	logic [15:0] command;
	logic [7:0]  frame_mode;
	logic [7:0]  param_byte;
	logic [7:0]  param_index;
	logic [7:0]  param_count;
	logic        frame_last;

	// Side information that travels with the byte on the input channel.
	bit             typed_row  = 1'b0;
	afd_pkg::item_t typed_want = '0;

	// Result words still owed by the block, oldest first.
	afd_pkg::item_t pending_words [$];
	int    mismatch_cnt = 0;
	int    in_bytes     = 0;
	int    burst_left   = 0;
	int    cycle_cnt    = 0;

	// The predictor's own copy of the parser state.
	afd_pkg::phase_t pr_phase = afd_pkg::PH_HUNT;
	logic [7:0]      pr_total = 8'd0;
	logic [7:0]      pr_seen  = 8'd0;
	logic [15:0]     pr_cmd   = 16'd0;
	logic [7:0]      pr_mode  = 8'd0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	accessory_frame_deframer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.item_kind   (item_kind),
		.command     (command),
		.frame_mode  (frame_mode),
		.param_byte  (param_byte),
		.param_index (param_index),
		.param_count (param_count),
		.frame_last  (frame_last)
	);

	// Advances the parser state by one received byte. Returns 1 and fills res
	// when the byte gives a result word: a parameter byte or the frame end.
	function automatic bit deframe_byte(input logic [7:0] b, output afd_pkg::item_t res);
		res = '0;
		res.command = pr_cmd;
		res.mode    = pr_mode;
		res.count   = pr_total;
		case (pr_phase)
			afd_pkg::PH_HUNT: begin
				if (b == afd_pkg::HDR_FIRST)
					pr_phase = afd_pkg::PH_HDR2;
			end
			afd_pkg::PH_HDR2: begin
				// 0xFF here keeps the parser waiting for 0x55.
				if (b == afd_pkg::HDR_SECOND)
					pr_phase = afd_pkg::PH_LEN;
				else if (b != afd_pkg::HDR_FIRST)
					pr_phase = afd_pkg::PH_HUNT;
			end
			afd_pkg::PH_LEN: begin
				if (b < afd_pkg::FIXED_PART || b > afd_pkg::MAX_LENGTH) begin
					pr_phase = afd_pkg::PH_HUNT;
				end else begin
					pr_total = b - afd_pkg::FIXED_PART;
					pr_seen  = 8'd0;
					pr_phase = afd_pkg::PH_MODE;
				end
			end
			afd_pkg::PH_MODE: begin
				pr_mode  = b;
				pr_phase = afd_pkg::PH_CMDH;
			end
			afd_pkg::PH_CMDH: begin
				pr_cmd   = {b, 8'h00};
				pr_phase = afd_pkg::PH_CMDL;
			end
			afd_pkg::PH_CMDL: begin
				pr_cmd[7:0] = b;
				pr_phase    = (pr_total == 8'd0) ? afd_pkg::PH_CHECK : afd_pkg::PH_PARAM;
			end
			afd_pkg::PH_PARAM: begin
				res.kind  = afd_pkg::KIND_PARAM;
				res.data  = b;
				res.index = pr_seen;
				res.last  = 1'b0;
				pr_seen   = pr_seen + 8'd1;
				if (pr_seen >= pr_total)
					pr_phase = afd_pkg::PH_CHECK;
				return 1'b1;
			end
			default: begin
				// The checksum byte: it is not verified, it only closes the frame.
				res.kind  = afd_pkg::KIND_END;
				res.last  = 1'b1;
				pr_phase  = afd_pkg::PH_HUNT;
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	task automatic note_failure(input string why, input afd_pkg::item_t want,
			input afd_pkg::item_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= SHOW_LIMIT) begin
			$display("%s: want kind=%0d cmd=%h mode=%h data=%h idx=%0d cnt=%0d last=%0d",
				why, want.kind, want.command, want.mode, want.data, want.index,
				want.count, want.last);
			$display("%s: got  kind=%0d cmd=%h mode=%h data=%h idx=%0d cnt=%0d last=%0d",
				why, got.kind, got.command, got.mode, got.data, got.index,
				got.count, got.last);
		end
	endtask

	// Both channels are watched here, at the rising edge, from the values that
	// held just before it. The input side is handled first so that a word
	// predicted in this cycle is already queued; the block can never answer a
	// byte in the cycle it takes it, so the order only matters for safety.
	always @(posedge clk) begin : scoreboard
		afd_pkg::item_t pred;
		afd_pkg::item_t got;
		afd_pkg::item_t want;
		bit             made;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_bytes++;
				made = deframe_byte(rx_byte, pred);
				if (typed_row)
					pending_words.push_back(typed_want);
				else if (made)
					pending_words.push_back(pred);
			end
			if (out_valid && out_ready) begin
				got = '{item_kind, command, frame_mode, param_byte, param_index,
					param_count, frame_last};
				if (pending_words.size() == 0) begin
					note_failure("unexpected word", NO_WORD, got);
				end else begin
					want = pending_words.pop_front();
					if (got !== want)
						note_failure("word mismatch", want, got);
				end
			end
		end
	end

	// The receiver switches between stall patterns: always ready,
	// coin flips, a short periodic stall, or long stretches of stall.
	always @(posedge clk) begin : receiver
		int rx_tick;
		int rx_mode;
		if (rx_tick % 256 == 0)
			rx_mode = $urandom_range(0, 3);
		rx_tick++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= 1'($urandom_range(0, 1));
			2: out_ready <= (rx_tick % 5) != 0;
			default: out_ready <= (rx_tick % 24) >= 12;
		endcase
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[accessory_frame_deframer] ERROR");
			$finish;
		end
	end

	// Offers one byte word and holds it until the block takes it. The sender
	// runs in bursts and goes quiet at the end of each burst.
	task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
			input afd_pkg::item_t want = '0);
		in_valid   <= 1'b1;
		rx_byte    <= b;
		typed_row  <= typed;
		typed_want <= want;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
				: $urandom_range(0, 12);
		end
	endtask

	// Holds the input back until every owed word has come out.
	task automatic drain_pause();
		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One random frame. Most are well formed with random content; the rest are
	// broken headers, bad lengths, repeated 0xFF and frames cut off early.
	task automatic send_frame();
		int pick;
		int len;
		int cut;
		int r;
		pick = $urandom_range(0, 99);
		// A little line noise between frames, kept clear of 0xFF.
		repeat ($urandom_range(0, 2))
			push_byte(8'($urandom_range(0, 254)));
		if (pick >= 94) begin
			push_byte(afd_pkg::HDR_FIRST);
			r = $urandom_range(0, 253);
			if (r >= afd_pkg::HDR_SECOND)
				r++;
			push_byte(8'(r));
		end else if (pick >= 84) begin
			push_byte(afd_pkg::HDR_FIRST);
			push_byte(afd_pkg::HDR_SECOND);
			push_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 2))
				: 8'($urandom_range(252, 255)));
		end else begin
			push_byte(afd_pkg::HDR_FIRST);
			if (pick >= 76)
				push_byte(afd_pkg::HDR_FIRST);
			push_byte(afd_pkg::HDR_SECOND);
			r = $urandom_range(0, 99);
			if (r < 2)
				len = afd_pkg::MAX_LENGTH;
			else if (r < 15)
				len = afd_pkg::FIXED_PART;
			else
				len = $urandom_range(4, 14);
			push_byte(8'(len));
			// A cut frame stops somewhere inside its body; the bytes that follow
			// are then read as the rest of it.
			cut = (pick >= 68) ? $urandom_range(0, len) : len + 1;
			for (int i = 0; i < len + 1 && i < cut; i++)
				push_byte(8'($urandom_range(0, 255)));
		end
	endtask

	initial begin : stimulus
		int frames;
		frames = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++)
			push_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].want);
		drain_pause();

		while (in_bytes < IN_BYTES) begin
			send_frame();
			frames++;
			if (frames % 40 == 0)
				drain_pause();
		end

		in_valid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatch_cnt == 0 && pending_words.size() == 0)
			$display("[accessory_frame_deframer] OK");
		else
			$display("[accessory_frame_deframer] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
